>>> sv/mmcs_pkg.sv
// Package for the multi-mode checksum engine: mode codes, register indexes,
// the Adler modulus and the per-byte update functions. No dependencies.
package mmcs_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SUM_W      = 32;

    localparam logic [15:0] ADLER_MOD = 16'd65521;

    typedef enum logic [1:0] {
        MODE_CRC_MSB  = 2'd0,
        MODE_CRC_REFL = 2'd1,
        MODE_ADLER    = 2'd2,
        MODE_BSD      = 2'd3
    } t_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MODE     = 3'd0,
        REG_WIDTH32  = 3'd1,
        REG_POLY     = 3'd2,
        REG_INIT     = 3'd3,
        REG_XOR_OUT  = 3'd4
    } t_cfg_reg;

    function automatic logic [SUM_W-1:0] width_mask(input logic is32);
        width_mask = is32 ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    endfunction

    // MSB-first CRC, eight shifts per byte
    function automatic logic [SUM_W-1:0] crc_msb_step(
        input logic [SUM_W-1:0] v_in,
        input logic [7:0]       data,
        input logic [SUM_W-1:0] poly,
        input logic             is32
    );
        logic [SUM_W-1:0] mask;
        logic [SUM_W-1:0] v;
        logic             top;
        mask = width_mask(is32);
        v    = v_in & mask;
        v    = is32 ? (v ^ {data, 24'd0}) : (v ^ {16'd0, data, 8'd0});
        for (int i = 0; i < 8; i++) begin
            top = is32 ? v[31] : v[15];
            v   = ({v[SUM_W-2:0], 1'b0} ^ (top ? (poly & mask) : '0)) & mask;
        end
        crc_msb_step = v;
    endfunction

    // reflected CRC, LSB first
    function automatic logic [SUM_W-1:0] crc_refl_step(
        input logic [SUM_W-1:0] v_in,
        input logic [7:0]       data,
        input logic [SUM_W-1:0] poly,
        input logic             is32
    );
        logic [SUM_W-1:0] mask;
        logic [SUM_W-1:0] v;
        mask = width_mask(is32);
        v    = (v_in & mask) ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            v = {1'b0, v[SUM_W-1:1]} ^ (v[0] ? (poly & mask) : '0);
        end
        crc_refl_step = v & mask;
    endfunction

    function automatic logic [SUM_W-1:0] adler_step(
        input logic [SUM_W-1:0] v_in,
        input logic [7:0]       data
    );
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, v_in[15:0]} + {9'd0, data};
        if (s1 >= {1'b0, ADLER_MOD}) begin
            s1 = s1 - {1'b0, ADLER_MOD};
        end
        s2 = {1'b0, v_in[31:16]} + {1'b0, s1[15:0]};
        if (s2 >= {1'b0, ADLER_MOD}) begin
            s2 = s2 - {1'b0, ADLER_MOD};
        end
        adler_step = {s2[15:0], s1[15:0]};
    endfunction

    // rotate right by one, then add the byte
    function automatic logic [SUM_W-1:0] bsd_step(
        input logic [SUM_W-1:0] v_in,
        input logic [7:0]       data
    );
        logic [15:0] s;
        s        = {v_in[0], v_in[15:1]};
        s        = s + {8'd0, data};
        bsd_step = {16'd0, s};
    endfunction

endpackage

>>> sv/multi_mode_checksum_engine_unit.sv
// Byte-serial checksum engine: MSB-first CRC, reflected CRC, Adler-32 and
// BSD 16-bit sum over a byte stream. Depends on mmcs_pkg.
//
// One byte is taken per clock unless a held output beat stalls the input; each
// byte yields one checksum beat in the cycle after it is accepted. The byte fold
// (eight unrolled CRC shifts, or the two Adler add/reduce steps) is combinational
// and feeds the running-value register. The output register frees as its beat is
// taken, so input and output can both move in the same cycle. Configuration writes
// take effect on the next accepted byte; tuser set loads init_value first.
module multi_mode_checksum_engine_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [7:0] data_byte
    input  logic                                i_s_axis_tuser,  // [0] start_of_block
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [mmcs_pkg::SUM_W-1:0]          o_m_axis_tdata,  // [31:0] checksum
    input  logic                                i_cfg_we,
    input  logic [mmcs_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [mmcs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import mmcs_pkg::*;

    t_mode              r_mode;
    logic               r_is32;
    logic [SUM_W-1:0]   r_poly;
    logic [SUM_W-1:0]   r_init;
    logic [SUM_W-1:0]   r_xor_out;
    logic [SUM_W-1:0]   r_running;
    logic               r_out_valid;
    logic [SUM_W-1:0]   r_out_data;

    logic               s_accept;
    logic [SUM_W-1:0]   base;
    logic [SUM_W-1:0]   n_running;
    logic [SUM_W-1:0]   out_mask;
    logic [SUM_W-1:0]   n_out_data;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        base = i_s_axis_tuser ? r_init : r_running;
        unique case (r_mode)
            MODE_CRC_MSB: begin
                n_running = crc_msb_step(base, i_s_axis_tdata, r_poly, r_is32);
                out_mask  = width_mask(r_is32);
            end
            MODE_CRC_REFL: begin
                n_running = crc_refl_step(base, i_s_axis_tdata, r_poly, r_is32);
                out_mask  = width_mask(r_is32);
            end
            MODE_ADLER: begin
                n_running = adler_step(base, i_s_axis_tdata);
                out_mask  = width_mask(1'b1);
            end
            MODE_BSD: begin
                n_running = bsd_step(base, i_s_axis_tdata);
                out_mask  = width_mask(1'b0);
            end
            default: begin
                n_running = base;
                out_mask  = '0;
            end
        endcase
        n_out_data = (n_running ^ r_xor_out) & out_mask;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_CRC_REFL;
            r_is32    <= 1'b1;
            r_poly    <= 32'hEDB8_8320;
            r_init    <= 32'hFFFF_FFFF;
            r_xor_out <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MODE:    r_mode    <= t_mode'(i_cfg_wdata[1:0]);
                REG_WIDTH32: r_is32    <= i_cfg_wdata[0];
                REG_POLY:    r_poly    <= i_cfg_wdata;
                REG_INIT:    r_init    <= i_cfg_wdata;
                REG_XOR_OUT: r_xor_out <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_running   <= n_running;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_data <= n_out_data;
        end
    end

    a_accept_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_out_valid)
        else $error("accepted beat produced no result");

    a_crc16_upper_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !r_is32 && (r_mode == MODE_CRC_MSB || r_mode == MODE_CRC_REFL))
        |=> (r_running[31:16] == 16'd0))
        else $error("16-bit CRC left upper running bits set");

    a_bsd_out_16: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_mode == MODE_BSD) |=> (r_out_data[31:16] == 16'd0))
        else $error("BSD sum result wider than 16 bits");

    a_adler_s1_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_mode == MODE_ADLER) |=> (r_running[15:0] < ADLER_MOD))
        else $error("Adler s1 not reduced");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_axis_tready)
        else $error("input stalled with empty output register");

endmodule

>>> bench/tb_multi_mode_checksum_engine_unit.sv
// Self-checking bench for multi_mode_checksum_engine_unit: directed rows, then random
// phases of byte blocks under random configs, each beat checked against a local fold
// or a pinned sum. Depends on mmcs_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb_multi_mode_checksum_engine_unit;
    import mmcs_pkg::*;

    localparam logic [16:0] ADLER_BASE    = 17'd65521;
    localparam logic [2:0]  REG_SPARE_LO  = 3'd5;
    localparam logic [2:0]  REG_SPARE_HI  = 3'd7;
    localparam int          RANDOM_ITEMS  = 1400;
    localparam int          LONG_HOLD     = 250;

    typedef enum logic { ROW_CFG, ROW_BYTE } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [31:0] val;
        logic        sob;
        logic        pinned;
        logic [31:0] sum;
    } t_stim_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [7:0]              i_s_axis_tdata;  // [7:0] data_byte
    logic                    i_s_axis_tuser;  // [0] start_of_block
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [SUM_W-1:0]        o_m_axis_tdata;  // [31:0] checksum
    logic                    i_cfg_we;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata;

    t_mode       cfg_mode = MODE_CRC_REFL;
    logic        cfg_wide = 1'b1;
    logic [31:0] cfg_poly = 32'hEDB8_8320;
    logic [31:0] cfg_init = 32'hFFFF_FFFF;
    logic [31:0] cfg_xor  = 32'hFFFF_FFFF;
    logic [31:0] run_sum  = 32'd0;

    logic [31:0] pending_sums[$];
    logic [31:0] oldest;
    t_stim_row   directed_rows[$];
    int          mismatches = 0;
    int          tx_calm = 0;
    int          rx_calm = 0;
    bit          stall_request = 1'b0;

    multi_mode_checksum_engine_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    // running value after one byte under the current config
    function automatic logic [31:0] fold_byte(input logic [31:0] cur, input logic [7:0] b);
        logic [31:0] msk;
        logic [31:0] v;
        logic [16:0] s1;
        logic [16:0] s2;
        logic [15:0] rot;
        msk = cfg_wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;
        v   = cur & msk;
        case (cfg_mode)
            MODE_CRC_MSB: begin
                v = v ^ (cfg_wide ? {b, 24'd0} : {16'd0, b, 8'd0});
                for (int k = 0; k < 8; k++) begin
                    if (cfg_wide ? v[31] : v[15]) begin
                        v = ((v << 1) ^ cfg_poly) & msk;
                    end else begin
                        v = (v << 1) & msk;
                    end
                end
            end
            MODE_CRC_REFL: begin
                v = v ^ {24'd0, b};
                for (int k = 0; k < 8; k++) begin
                    v = v[0] ? ((v >> 1) ^ (cfg_poly & msk)) : (v >> 1);
                end
            end
            MODE_ADLER: begin
                s1 = {1'b0, cur[15:0]} + {9'd0, b};
                if (s1 >= ADLER_BASE) begin
                    s1 = s1 - ADLER_BASE;
                end
                s2 = {1'b0, cur[31:16]} + {1'b0, s1[15:0]};
                if (s2 >= ADLER_BASE) begin
                    s2 = s2 - ADLER_BASE;
                end
                v = {s2[15:0], s1[15:0]};
            end
            default: begin
                rot = {cur[0], cur[15:1]} + {8'd0, b};
                v   = {16'd0, rot};
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] shown_sum(input logic [31:0] v);
        logic full;
        full = (cfg_mode == MODE_ADLER) || (cfg_mode != MODE_BSD && cfg_wide);
        return (v ^ cfg_xor) & (full ? 32'hFFFF_FFFF : 32'h0000_FFFF);
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(8, 48);
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic t_stim_row cfg_row(input logic [2:0] idx, input logic [31:0] val);
        t_stim_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic t_stim_row byte_row(input logic [7:0] b, input logic sob);
        t_stim_row r;
        r      = '0;
        r.kind = ROW_BYTE;
        r.val  = {24'd0, b};
        r.sob  = sob;
        return r;
    endfunction

    function automatic t_stim_row byte_pin(input logic [7:0] b, input logic sob,
                                           input logic [31:0] sum);
        t_stim_row r;
        r        = byte_row(b, sob);
        r.pinned = 1'b1;
        r.sum    = sum;
        return r;
    endfunction

    function automatic logic [31:0] pick_poly();
        case ($urandom_range(0, 9))
            0:       return 32'h04C1_1DB7;
            1:       return 32'hEDB8_8320;
            2:       return 32'h82F6_3B78;
            3:       return 32'h0000_A001;
            4:       return 32'h0000_1021;
            5:       return 32'h0000_8005;
            6:       return 32'h0000_0000;
            7:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0001;
            3:       return 32'hFFF1_FFF0;
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_sums.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_MODE:    cfg_mode = t_mode'(val[1:0]);
            REG_WIDTH32: cfg_wide = val[0];
            REG_POLY:    cfg_poly = val;
            REG_INIT:    cfg_init = val;
            REG_XOR_OUT: cfg_xor  = val;
            default: ;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input logic sob, input logic pinned,
                             input logic [31:0] pin_sum);
        int gap;
        gap = draw_wait(tx_calm);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = b;
        i_s_axis_tuser  = sob;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (sob) begin
            run_sum = cfg_init;
        end
        run_sum = fold_byte(run_sum, b);
        pending_sums.push_back(pinned ? pin_sum : shown_sum(run_sum));
    endtask

    task automatic random_phase(input int n_items, input bit squeeze);
        int sent;
        int run_len;
        bit carry_on;
        sent     = 0;
        carry_on = ($urandom_range(0, 3) == 0);
        cfg_write(REG_MODE, ($urandom & 32'hFFFF_FFFC) | $urandom_range(0, 3));
        if ($urandom_range(0, 1)) cfg_write(REG_WIDTH32, $urandom);
        if ($urandom_range(0, 1)) cfg_write(REG_POLY, pick_poly());
        if ($urandom_range(0, 1)) cfg_write(REG_INIT, pick_word());
        if ($urandom_range(0, 1)) cfg_write(REG_XOR_OUT, pick_word());
        if ($urandom_range(0, 7) == 0) begin
            cfg_write(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
        end
        while (sent < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'b0, 32'd0);
                sent++;
            end else begin
                run_len = $urandom_range(1, 24);
                if (run_len > n_items - sent) begin
                    run_len = n_items - sent;
                end
                for (int k = 0; k < run_len; k++) begin
                    push_byte(8'($urandom_range(0, 255)), (k == 0) && !carry_on,
                              1'b0, 32'd0);
                end
                sent += run_len;
            end
            carry_on = 1'b0;
            if (squeeze) begin
                stall_request = 1'b1;
                squeeze       = 1'b0;
            end
        end
    endtask

    initial begin
        int random_total;
        int phase;
        int span;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_s_axis_tuser  = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        directed_rows = '{
            byte_pin(8'h00, 1'b0, 32'hFFFF_FFFF),   // running value still zero from reset
            byte_pin(8'h00, 1'b1, 32'hD202_EF8D),
            byte_pin(8'hFF, 1'b1, 32'hFF00_0000),
            byte_row(8'hFF, 1'b0),
            cfg_row(REG_MODE, 32'(MODE_CRC_MSB)),
            cfg_row(REG_POLY, 32'h04C1_1DB7),
            byte_row(8'h00, 1'b1),
            byte_row(8'h80, 1'b0),
            cfg_row(REG_WIDTH32, 32'd0),
            cfg_row(REG_POLY, 32'd0),
            cfg_row(REG_XOR_OUT, 32'd0),
            byte_pin(8'h00, 1'b1, 32'h0000_FF00),   // upper init bits dropped
            cfg_row(REG_POLY, 32'hFFFF_FFFF),
            byte_row(8'hFF, 1'b1),
            byte_row(8'h01, 1'b0),
            cfg_row(REG_POLY, 32'h0000_1021),
            byte_row(8'h00, 1'b1),
            byte_row(8'h7F, 1'b0),
            cfg_row(REG_MODE, 32'(MODE_CRC_REFL)),
            cfg_row(REG_POLY, 32'h0000_A001),
            byte_row(8'h01, 1'b1),
            byte_row(8'h80, 1'b0),
            cfg_row(REG_WIDTH32, 32'd1),
            cfg_row(REG_POLY, 32'h82F6_3B78),
            cfg_row(REG_XOR_OUT, 32'hFFFF_FFFF),
            byte_row(8'h00, 1'b1),
            cfg_row(REG_MODE, 32'(MODE_ADLER)),
            cfg_row(REG_INIT, 32'd1),
            cfg_row(REG_XOR_OUT, 32'd0),
            byte_pin(8'h61, 1'b1, 32'h0062_0062),
            byte_pin(8'h62, 1'b0, 32'h0126_00C4),
            cfg_row(REG_INIT, 32'hFFFF_FFFF),       // both halves above the modulus
            byte_row(8'hFF, 1'b1),
            byte_row(8'h00, 1'b0),
            cfg_row(REG_INIT, 32'hFFF0_FFF0),
            byte_row(8'hFF, 1'b1),
            cfg_row(REG_MODE, 32'(MODE_BSD)),
            cfg_row(REG_INIT, 32'd0),
            byte_pin(8'hFF, 1'b1, 32'h0000_00FF),
            byte_pin(8'hFF, 1'b0, 32'h0000_817E),
            cfg_row(REG_XOR_OUT, 32'hFFFF_FFFF),
            byte_row(8'h01, 1'b0),
            cfg_row(REG_MODE, 32'(MODE_CRC_REFL)),  // no reload on mode switch
            byte_row(8'h00, 1'b0),
            cfg_row(REG_SPARE_LO, 32'hFFFF_FFFF),
            cfg_row(REG_SPARE_HI, 32'd0),
            byte_row(8'h55, 1'b0)
        };
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                cfg_write(directed_rows[r].idx, directed_rows[r].val);
            end else begin
                push_byte(directed_rows[r].val[7:0], directed_rows[r].sob,
                          directed_rows[r].pinned, directed_rows[r].sum);
            end
        end
        random_total = 0;
        phase        = 0;
        while (random_total < RANDOM_ITEMS) begin
            span = $urandom_range(40, 120);
            random_phase(span, (phase == 2) || (phase == 9));
            random_total += span;
            phase++;
        end
        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        int hold;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = draw_wait(rx_calm);
            if (stall_request) begin
                stall_request = 1'b0;
                hold          = LONG_HOLD;
            end
            repeat (hold) begin
                @(negedge i_clk);
                i_m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: checksum beat %08h with nothing pending", $time, o_m_axis_tdata);
                mismatches++;
            end else begin
                oldest = pending_sums.pop_front();
                if (o_m_axis_tdata !== oldest) begin
                    $display("%0t: checksum mismatch, expected %08h, got %08h",
                             $time, oldest, o_m_axis_tdata);
                    mismatches++;
                end
            end
        end
    end

endmodule

>>> sim.f
sv/mmcs_pkg.sv
sv/multi_mode_checksum_engine_unit.sv
bench/tb_multi_mode_checksum_engine_unit.sv
